// File: src/lfpd_pkg.sv
// shared types, widths and constants for the line-follower pd steering block
// no dependencies; imported by every module of the block
package lfpd_pkg;

    localparam int unsigned SensorCount = 7;
    localparam int unsigned PosW        = 11;  // signed q3.8 position
    localparam int unsigned RecipW      = 17;
    localparam int unsigned AccW        = 25;  // signed q9.16 correction
    localparam int unsigned SpeedW      = 9;
    localparam int unsigned CfgIdxW     = 3;
    localparam int unsigned CfgDataW    = 12;

    localparam logic [CfgIdxW-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KP_GAIN      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KD_GAIN      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ACTIVE_LOW   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SEARCH_SPEED = 3'd4;

    localparam logic [7:0]  RST_BASE_SPEED   = 8'd50;
    localparam logic [11:0] RST_KP_GAIN      = 12'd512;
    localparam logic [11:0] RST_KD_GAIN      = 12'd26;
    localparam logic        RST_ACTIVE_LOW   = 1'b1;
    localparam logic [7:0]  RST_SEARCH_SPEED = 8'd90;

    localparam logic signed [SpeedW:0] SpeedMax = 10'sd255;
    localparam logic signed [SpeedW:0] SpeedMin = -10'sd255;

    // one classified sample handed from front to back
    typedef struct packed {
        logic                   lost;
        logic signed [PosW-1:0] pos;
    } t_cmd;

    // ceil(2^16 / count), exact after the shift for numerators below 2^16/7
    function automatic logic [RecipW-1:0] recip_of(input logic [2:0] count);
        logic [RecipW-1:0] r;
        case (count)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            3'd6:    r = 17'd10923;
            3'd7:    r = 17'd9363;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: src/line_follower_pd_steering_top.sv
// top level of the line-follower pd steering block: config registers,
// front end, queue and back end; depends on lfpd_pkg, lfpd_front, lfpd_fifo, lfpd_back
//
// usage:
//   sensor channel: i_sensor_valid / o_sensor_stall carry one 7-bit sample a beat,
//   bit 0 leftmost. result channel: o_result_valid / i_result_stall carry the
//   signed left and right speeds and the line-lost flag, one result per sample.
//   config port: i_cfg_we writes i_cfg_wdata into register i_cfg_index
//   (0 base, 1 kp, 2 kd, 3 active low, 4 search speed); other indexes are dropped.
//   write config only while no sample is in flight.
// timing:
//   the front end works through capture, weight sum and reciprocal multiply, and
//   hand-off into the queue; the back end through fetch, kp multiply, kd multiply
//   and accumulate, and saturate into the output register.
//   neither end takes a new sample before the last one has left it; the back end's
//   multiply steps set the sustained throughput.
// reset: synchronous active low; registers return to defaults, stored error is
//   cleared and both queue and output register empty.
// stall: a stalled result holds; the two-entry queue keeps taking samples until full,
//   then the sensor channel stalls.
module line_follower_pd_steering_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_sensor_valid,
    output logic                           o_sensor_stall,
    input  logic [6:0]                     i_sensor_bits,
    output logic                           o_result_valid,
    input  logic                           i_result_stall,
    output logic signed [lfpd_pkg::SpeedW-1:0] o_left_speed,
    output logic signed [lfpd_pkg::SpeedW-1:0] o_right_speed,
    output logic                           o_line_lost,
    input  logic                           i_cfg_we,
    input  logic [lfpd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [lfpd_pkg::CfgDataW-1:0]  i_cfg_wdata
);
    import lfpd_pkg::*;

    logic [7:0]  r_base_speed;
    logic [11:0] r_kp_gain;
    logic [11:0] r_kd_gain;
    logic        r_active_low;
    logic [7:0]  r_search_speed;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_valid;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed   <= RST_BASE_SPEED;
            r_kp_gain      <= RST_KP_GAIN;
            r_kd_gain      <= RST_KD_GAIN;
            r_active_low   <= RST_ACTIVE_LOW;
            r_search_speed <= RST_SEARCH_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE_SPEED:   r_base_speed   <= i_cfg_wdata[7:0];
                REG_KP_GAIN:      r_kp_gain      <= i_cfg_wdata;
                REG_KD_GAIN:      r_kd_gain      <= i_cfg_wdata;
                REG_ACTIVE_LOW:   r_active_low   <= i_cfg_wdata[0];
                REG_SEARCH_SPEED: r_search_speed <= i_cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    lfpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_sensor_valid),
        .o_stall       (o_sensor_stall),
        .i_sensor_bits (i_sensor_bits),
        .i_active_low  (r_active_low),
        .o_cmd_valid   (front_valid),
        .o_cmd         (front_cmd),
        .i_cmd_full    (queue_full)
    );

    lfpd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (front_valid),
        .i_wr_data (front_cmd),
        .i_pop     (back_pop),
        .o_rd_data (queue_cmd),
        .o_empty   (queue_empty),
        .o_full    (queue_full)
    );

    lfpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (queue_empty),
        .i_cmd          (queue_cmd),
        .o_pop          (back_pop),
        .i_base_speed   (r_base_speed),
        .i_kp_gain      (r_kp_gain),
        .i_kd_gain      (r_kd_gain),
        .i_search_speed (r_search_speed),
        .o_valid        (o_result_valid),
        .i_stall        (i_result_stall),
        .o_left_speed   (o_left_speed),
        .o_right_speed  (o_right_speed),
        .o_line_lost    (o_line_lost)
    );

endmodule

// File: src/lfpd_front.sv
// front end: takes sensor beats, finds the line and its q3.8 position
// depends on lfpd_pkg
module lfpd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [6:0]            i_sensor_bits,
    input  logic                  i_active_low,
    output logic                  o_cmd_valid,
    output lfpd_pkg::t_cmd        o_cmd,
    input  logic                  i_cmd_full
);
    import lfpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SensorCount-1:0] r_seen;
    logic [9:0]             r_mag;
    logic                   r_neg;
    logic                   r_lost;

    logic signed [4:0]      sum;
    logic [2:0]             count;
    logic [3:0]             abs_sum;
    logic [28:0]            prod;
    logic                   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // weights run -3..+3 from bit 0 to bit 6
    always_comb begin
        sum   = '0;
        count = '0;
        for (int i = 0; i < SensorCount; i++) begin
            if (r_seen[i]) begin
                sum   = sum + 5'(signed'(i - 3));
                count = count + 3'd1;
            end
        end
        abs_sum = sum[4] ? 4'(-sum) : sum[3:0];
        prod    = {13'd0, abs_sum, 8'd0} * {12'd0, recip_of(count)};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CALC;
            S_CALC:  n_state = S_PUSH;
            S_PUSH:  if (!i_cmd_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seen <= i_active_low ? ~i_sensor_bits : i_sensor_bits;
        end
        if (r_state == S_CALC) begin
            r_mag  <= prod[25:16];
            r_neg  <= sum[4];
            r_lost <= (count == 3'd0);
        end
    end

    assign o_cmd_valid = (r_state == S_PUSH);
    assign o_cmd.lost  = r_lost;
    assign o_cmd.pos   = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

// File: src/lfpd_fifo.sv
// two-entry queue of classified samples between front and back
// depends on lfpd_pkg
module lfpd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lfpd_pkg::t_cmd i_wr_data,
    input  logic           i_pop,
    output lfpd_pkg::t_cmd o_rd_data,
    output logic           o_empty,
    output logic           o_full
);
    import lfpd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty   = (r_count == 2'd0);
    assign o_full    = (r_count == 2'd2);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_wr_data;
    end

endmodule

// File: src/lfpd_back.sv
// back end: pd law over two multiply steps, saturation, search spin, output register
// depends on lfpd_pkg
module lfpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_empty,
    input  lfpd_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    input  logic [7:0]                  i_base_speed,
    input  logic [11:0]                 i_kp_gain,
    input  logic [11:0]                 i_kd_gain,
    input  logic [7:0]                  i_search_speed,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [lfpd_pkg::SpeedW-1:0] o_left_speed,
    output logic signed [lfpd_pkg::SpeedW-1:0] o_right_speed,
    output logic                        o_line_lost
);
    import lfpd_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MULP = 4'b0010,
        B_MULD = 4'b0100,
        B_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    t_cmd                    r_cmd;
    logic signed [AccW-1:0]  r_acc;
    logic signed [PosW-1:0]  r_last;
    logic                    r_out_valid;
    logic signed [SpeedW-1:0] r_left;
    logic signed [SpeedW-1:0] r_right;
    logic                    r_lost;

    logic signed [12:0]       kp_s;
    logic signed [12:0]       kd_s;
    logic signed [23:0]       prod_p;
    logic signed [PosW:0]     deriv;
    logic signed [AccW-1:0]   prod_d;
    logic signed [AccW-1:0]   acc_adj;
    logic signed [SpeedW-1:0] ci;
    logic signed [SpeedW:0]   base_s;
    logic signed [SpeedW:0]   left_raw;
    logic signed [SpeedW:0]   right_raw;
    logic signed [SpeedW-1:0] left_sat;
    logic signed [SpeedW-1:0] right_sat;
    logic signed [SpeedW-1:0] spin;
    logic                     out_free;
    logic                     load_out;

    assign kp_s   = $signed({1'b0, i_kp_gain});
    assign kd_s   = $signed({1'b0, i_kd_gain});
    assign prod_p = kp_s * r_cmd.pos;
    assign deriv  = {r_cmd.pos[PosW-1], r_cmd.pos} - {r_last[PosW-1], r_last};
    assign prod_d = kd_s * deriv;

    // truncate toward zero: bias negative values before the shift
    assign acc_adj   = r_acc + (r_acc[AccW-1] ? 25'sd65535 : 25'sd0);
    assign ci        = acc_adj[AccW-1:16];
    assign base_s    = $signed({2'b00, i_base_speed});
    assign left_raw  = base_s - {ci[SpeedW-1], ci};
    assign right_raw = base_s + {ci[SpeedW-1], ci};

    always_comb begin
        if (left_raw > SpeedMax) begin
            left_sat = SpeedMax[SpeedW-1:0];
        end else if (left_raw < SpeedMin) begin
            left_sat = SpeedMin[SpeedW-1:0];
        end else begin
            left_sat = left_raw[SpeedW-1:0];
        end
        if (right_raw > SpeedMax) begin
            right_sat = SpeedMax[SpeedW-1:0];
        end else if (right_raw < SpeedMin) begin
            right_sat = SpeedMin[SpeedW-1:0];
        end else begin
            right_sat = right_raw[SpeedW-1:0];
        end
    end

    // spin toward the side the line was last seen on
    assign spin = r_last[PosW-1] ? -$signed({1'b0, i_search_speed})
                                 : $signed({1'b0, i_search_speed});

    assign out_free = !r_out_valid || !i_stall;
    assign load_out = (r_state == B_OUT) && out_free;
    assign o_pop    = (r_state == B_IDLE) && !i_cmd_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_cmd_empty) n_state = B_MULP;
            B_MULP:  n_state = B_MULD;
            B_MULD:  n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load_out && !r_cmd.lost) begin
                r_last <= r_cmd.pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == B_MULP) begin
            r_acc <= {prod_p[23], prod_p};
        end
        if (r_state == B_MULD) begin
            r_acc <= r_acc + prod_d;
        end
        if (load_out) begin
            r_lost  <= r_cmd.lost;
            r_left  <= r_cmd.lost ? spin : left_sat;
            r_right <= r_cmd.lost ? -spin : right_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_line_lost   = r_lost;

endmodule

// File: tb/line_follower_pd_steering_top_tb.sv
// self-checking testbench for line_follower_pd_steering_top: a directed table,
// then random sensor beats under several register settings, checked by a pd predictor
// depends on lfpd_pkg and the line_follower_pd_steering_top rtl
module line_follower_pd_steering_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int ResetCycles   = 5;
    localparam int IdleSlack     = 16;
    localparam int RunLimitNs    = 3_000_000;
    localparam int PhaseCount    = 8;
    localparam int BeatsPerPhase = 165;
    localparam int CenterSensor  = SensorCount / 2;
    localparam int PosScale      = 256;    // q3.8
    localparam int CorrScale     = 65536;  // q9.16 down to integer
    localparam logic [CfgIdxW-1:0] REG_PAST_LAST = REG_SEARCH_SPEED + 3'd1;

    typedef struct packed {
        logic signed [SpeedW-1:0] left;
        logic signed [SpeedW-1:0] right;
        logic                     lost;
    } t_speed_cmd;

    // one directed beat; known marks a row whose speeds are typed in
    typedef struct packed {
        logic [SensorCount-1:0]   raw;
        logic                     known;
        logic signed [SpeedW-1:0] left;
        logic signed [SpeedW-1:0] right;
        logic                     lost;
    } t_sensor_row;

    localparam int DirectedCount = 23;
    // reset settings: active low, base 50, kp 2.0, kd ~0.1, search 90
    localparam t_sensor_row DirectedRows [DirectedCount] = '{
        '{7'h7F, 1'b1,  9'sd90, -9'sd90, 1'b1},  // nothing seen, stored error zero
        '{7'h77, 1'b1,  9'sd50,  9'sd50, 1'b0},  // center only
        '{7'h7E, 1'b0,  9'sd0,   9'sd0,  1'b0},  // leftmost only
        '{7'h7F, 1'b1, -9'sd90,  9'sd90, 1'b1},  // lost after left
        '{7'h7F, 1'b1, -9'sd90,  9'sd90, 1'b1},  // still lost, error kept
        '{7'h3F, 1'b0,  9'sd0,   9'sd0,  1'b0},  // rightmost only
        '{7'h7F, 1'b1,  9'sd90, -9'sd90, 1'b1},
        '{7'h00, 1'b1,  9'sd50,  9'sd50, 1'b0},  // all seen, small kd term truncates
        '{7'h7F, 1'b1,  9'sd90, -9'sd90, 1'b1},
        '{7'h3C, 1'b0,  9'sd0,   9'sd0,  1'b0},  // three sensors, inexact division
        '{7'h7F, 1'b1, -9'sd90,  9'sd90, 1'b1},
        '{7'h7C, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h1F, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h55, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h2A, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h7D, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h7B, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h6F, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h5F, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h0F, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h78, 1'b0,  9'sd0,   9'sd0,  1'b0},
        '{7'h7F, 1'b1, -9'sd90,  9'sd90, 1'b1},
        '{7'h77, 1'b0,  9'sd0,   9'sd0,  1'b0}
    };

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_sensor_valid = 1'b0;
    logic [SensorCount-1:0] i_sensor_bits  = '0;
    logic                   i_result_stall = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]     i_cfg_index    = '0;
    logic [CfgDataW-1:0]    i_cfg_wdata    = '0;
    logic                   o_sensor_stall;
    logic                   o_result_valid;
    logic signed [SpeedW-1:0] o_left_speed;
    logic signed [SpeedW-1:0] o_right_speed;
    logic                   o_line_lost;

    // predictor copy of the registers and the stored position error
    int cfg_base       = RST_BASE_SPEED;
    int cfg_kp         = RST_KP_GAIN;
    int cfg_kd         = RST_KD_GAIN;
    int cfg_active_low = RST_ACTIVE_LOW;
    int cfg_search     = RST_SEARCH_SPEED;
    int steer_err      = 0;

    t_speed_cmd pending_cmds[$];
    int mismatch_count = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int stall_run      = 0;

    line_follower_pd_steering_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sensor_valid (i_sensor_valid),
        .o_sensor_stall (o_sensor_stall),
        .i_sensor_bits  (i_sensor_bits),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_left_speed   (o_left_speed),
        .o_right_speed  (o_right_speed),
        .o_line_lost    (o_line_lost),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    function automatic int clamp_speed(input int v);
        if (v > SpeedMax) return int'(SpeedMax);
        if (v < SpeedMin) return int'(SpeedMin);
        return v;
    endfunction

    function automatic t_speed_cmd predict_steering(input logic [SensorCount-1:0] raw);
        t_speed_cmd cmd;
        logic [SensorCount-1:0] seen;
        int k, sum, cnt, pos, corr, ci, lft, rgt;
        seen = (cfg_active_low != 0) ? ~raw : raw;
        sum  = 0;
        cnt  = 0;
        for (k = 0; k < SensorCount; k++) begin
            if (seen[k]) begin
                sum += k - CenterSensor;
                cnt++;
            end
        end
        if (cnt == 0) begin
            // spin toward the side the line was last seen on
            lft = (steer_err >= 0) ? cfg_search : -cfg_search;
            rgt = -lft;
            cmd.lost = 1'b1;
        end else begin
            pos  = (sum * PosScale) / cnt;
            corr = cfg_kp * pos + cfg_kd * (pos - steer_err);
            ci   = corr / CorrScale;
            lft  = clamp_speed(cfg_base - ci);
            rgt  = clamp_speed(cfg_base + ci);
            cmd.lost  = 1'b0;
            steer_err = pos;
        end
        cmd.left  = lft[SpeedW-1:0];
        cmd.right = rgt[SpeedW-1:0];
        return cmd;
    endfunction

    // mostly a narrow run of sensors on the line, some lost beats, some noise
    function automatic logic [SensorCount-1:0] pick_sample();
        logic [SensorCount-1:0] seen;
        int kind, span, start;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            seen = '0;
        end else if (kind < 7) begin
            span  = $urandom_range(1, 3);
            start = $urandom_range(0, SensorCount - span);
            seen  = ((7'd1 << span) - 7'd1) << start;
        end else begin
            seen = SensorCount'($urandom);
        end
        return (cfg_active_low != 0) ? ~seen : seen;
    endfunction

    task automatic send_sample(input logic [SensorCount-1:0] raw, input logic known,
                               input t_speed_cmd typed_cmd);
        t_speed_cmd predicted;
        if (burst_left == 0) begin
            if ($urandom_range(0, 15) == 0) begin
                i_sensor_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_cmds.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                i_sensor_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        i_sensor_valid <= 1'b1;
        i_sensor_bits  <= raw;
        @(posedge i_clk);
        while (o_sensor_stall) @(posedge i_clk);
        burst_left--;
        predicted = predict_steering(raw);
        pending_cmds.push_back(known ? typed_cmd : predicted);
    endtask

    task automatic wait_idle();
        i_sensor_valid <= 1'b0;
        burst_left = 0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (IdleSlack) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_BASE_SPEED:   cfg_base       = data[7:0];
            REG_KP_GAIN:      cfg_kp         = data[11:0];
            REG_KD_GAIN:      cfg_kd         = data[11:0];
            REG_ACTIVE_LOW:   cfg_active_low = data[0];
            REG_SEARCH_SPEED: cfg_search     = data[7:0];
            default: ;
        endcase
    endtask

    // all five registers plus one write to an unused index; we drops once at the end
    task automatic apply_settings(input logic [CfgDataW-1:0] base, input logic [CfgDataW-1:0] kp,
                                  input logic [CfgDataW-1:0] kd, input logic [CfgDataW-1:0] al,
                                  input logic [CfgDataW-1:0] search);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_ACTIVE_LOW, al);
        write_reg(REG_SEARCH_SPEED, search);
        write_reg(REG_PAST_LAST + CfgIdxW'($urandom_range(0, 2)), CfgDataW'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // receiver alternates between open, choppy and mostly-stalled stretches
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(20, 200);
        end
        stall_run--;
        case (stall_mode)
            0:       i_result_stall <= 1'b0;
            1:       i_result_stall <= ($urandom_range(0, 1) == 1);
            default: i_result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_speed_cmd want;
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("result beat with nothing pending: left %0d right %0d lost %0b",
                       o_left_speed, o_right_speed, o_line_lost);
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_left_speed !== want.left) begin
                    $error("left_speed: expected %0d, got %0d", want.left, o_left_speed);
                    mismatch_count++;
                end
                if (o_right_speed !== want.right) begin
                    $error("right_speed: expected %0d, got %0d", want.right, o_right_speed);
                    mismatch_count++;
                end
                if (o_line_lost !== want.lost) begin
                    $error("line_lost: expected %0b, got %0b", want.lost, o_line_lost);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #(RunLimitNs);
        $display("line_follower_pd_steering_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_speed_cmd row_cmd;
        int phase, n, r;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DirectedCount; r++) begin
            row_cmd.left  = DirectedRows[r].left;
            row_cmd.right = DirectedRows[r].right;
            row_cmd.lost  = DirectedRows[r].lost;
            send_sample(DirectedRows[r].raw, DirectedRows[r].known, row_cmd);
        end

        for (phase = 0; phase < PhaseCount; phase++) begin
            if (phase != 0) begin
                wait_idle();
                case (phase)
                    1: apply_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'hFFF);
                    2: apply_settings(12'h000, 12'h000, 12'h000, 12'h001, 12'h000);
                    3: apply_settings(12'h080, 12'hFFF, 12'h000, 12'hFFE, 12'h001);
                    4: apply_settings(12'h0FF, 12'h000, 12'hFFF, 12'hFFF, 12'h0FF);
                    default: apply_settings(CfgDataW'($urandom), CfgDataW'($urandom),
                                            CfgDataW'($urandom), CfgDataW'($urandom),
                                            CfgDataW'($urandom));
                endcase
            end
            for (n = 0; n < BeatsPerPhase; n++) begin
                row_cmd = '0;
                send_sample(pick_sample(), 1'b0, row_cmd);
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("line_follower_pd_steering_top: match");
        end else begin
            $display("line_follower_pd_steering_top: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
src/lfpd_pkg.sv
src/lfpd_front.sv
src/lfpd_fifo.sv
src/lfpd_back.sv
src/line_follower_pd_steering_top.sv
tb/line_follower_pd_steering_top_tb.sv
